>>> design/assert_macros.svh
// assertion macros used by the port-level checker in design/htd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/htd_pkg.sv
// types, codes and helpers shared by the huffman table decoder modules
package htd_pkg;

  localparam int TABLE_SIZE_DEF   = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int REQ_W  = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int CNT_W  = 48;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BIT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_HOLD
  } seq_state_t;

  typedef struct packed {
    logic wr_en;
    logic clr;
  } tbl_ctl_t;

  // keep only the low len bits of a code
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len,
                                                  input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] m;
    if (len >= LEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return code & m;
  endfunction

endpackage

>>> design/htd_table.sv
// code table memory with per-entry valid bits and a registered read port
module htd_table
  import htd_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_ctl_t          ctl,
  input  logic [IW-1:0]     wr_idx,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [CODE_W-1:0] wr_code,
  input  logic [IW-1:0]     rd_idx,
  output logic [LEN_W-1:0]  rd_len,
  output logic [CODE_W-1:0] rd_code,
  output logic              rd_ok
);

  logic [LEN_W-1:0]  len_mem  [TABLE_SIZE];
  logic [CODE_W-1:0] code_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      len_mem[wr_idx]  <= wr_len;
      code_mem[wr_idx] <= wr_code;
    end
    rd_len  <= len_mem[rd_idx];
    rd_code <= code_mem[rd_idx];
  end

  // an entry never written since reset or clear reads as absent
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid_bits <= '0;
    end else if (ctl.wr_en) begin
      valid_bits[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= valid_bits[rd_idx];
  end

endmodule

>>> design/htd_seq.sv
// request sequencer: prefix, bit counter, table scan and compare unit
module htd_seq
  import htd_pkg::*;
#(
  parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [SYM_W-1:0]  entry_symbol,
  input  logic [LEN_W-1:0]  entry_length,
  input  logic [CODE_W-1:0] entry_code,
  input  logic              coded_bit,
  input  logic [CNT_W-1:0]  limit,
  input  logic              out_free,
  output logic              res_valid,
  output logic              res_symbol_valid,
  output logic [SYM_W-1:0]  res_symbol,
  output logic [STAT_W-1:0] res_status,
  output tbl_ctl_t          tbl_ctl,
  output logic [IW-1:0]     tbl_wr_idx,
  output logic [LEN_W-1:0]  tbl_wr_len,
  output logic [CODE_W-1:0] tbl_wr_code,
  output logic [IW-1:0]     tbl_rd_idx,
  input  logic [LEN_W-1:0]  tbl_rd_len,
  input  logic [CODE_W-1:0] tbl_rd_code,
  input  logic              tbl_rd_ok
);

  localparam int PW  = MAX_CODE_LEN;
  localparam int PLW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW  = (PW > CODE_W) ? PW : CODE_W;
  localparam int LCW = (PLW > LEN_W) ? PLW : LEN_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  seq_state_t state, state_next;

  logic [PW-1:0]    prefix_bits;
  logic [PLW-1:0]   prefix_len;
  logic [CNT_W-1:0] bits_consumed;
  logic [IW-1:0]    scan_addr;
  logic             issuing;
  logic             rd_live;
  logic [IW-1:0]    rd_idx;

  logic accept, limited, start_scan, sym_in_range;
  logic scan_hit, scan_end, prefix_full;
  logic [CW-1:0]  code_x, pre_x;
  logic [LCW-1:0] len_x, plen_x;

  assign accept       = in_valid && in_ready;
  assign limited      = bits_consumed >= limit;
  assign start_scan   = accept && (req_type == REQ_BIT) && !limited;
  assign sym_in_range = {1'b0, entry_symbol} < (SYM_W + 1)'(TABLE_SIZE);

  // compare unit: one stored entry against the prefix per cycle
  assign code_x   = CW'(tbl_rd_code);
  assign pre_x    = CW'(prefix_bits);
  assign len_x    = LCW'(tbl_rd_len);
  assign plen_x   = LCW'(prefix_len);
  assign scan_hit = rd_live && tbl_rd_ok && (tbl_rd_len != '0) &&
                    (len_x == plen_x) && (code_x == pre_x);
  assign scan_end = rd_live && (rd_idx == LAST_IDX);
  assign prefix_full = prefix_len >= PLW'(MAX_CODE_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (start_scan) begin
          state_next = SEQ_SCAN;
        end else if (accept) begin
          state_next = SEQ_HOLD;
        end
      end
      SEQ_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = SEQ_HOLD;
        end
      end
      SEQ_HOLD: begin
        if (out_free) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    tbl_ctl.wr_en = 1'b0;
    tbl_ctl.clr   = 1'b0;
    case (state)
      SEQ_IDLE: begin
        in_ready      = 1'b1;
        tbl_ctl.wr_en = in_valid && (req_type == REQ_LOAD) && sym_in_range;
        tbl_ctl.clr   = in_valid && (req_type == REQ_CLEAR);
      end
      SEQ_HOLD: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign tbl_wr_idx  = IW'(entry_symbol);
  assign tbl_wr_len  = entry_length;
  assign tbl_wr_code = code_mask(entry_length, entry_code);
  assign tbl_rd_idx  = scan_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bits   <= '0;
      prefix_len    <= '0;
      bits_consumed <= '0;
      issuing       <= 1'b0;
      rd_live       <= 1'b0;
    end else begin
      if (accept) begin
        case (req_type)
          REQ_CLEAR: begin
            prefix_bits <= '0;
            prefix_len  <= '0;
          end
          REQ_BIT: begin
            if (!limited) begin
              bits_consumed <= bits_consumed + CNT_W'(1);
              prefix_bits   <= {prefix_bits[PW-2:0], coded_bit};
              prefix_len    <= prefix_len + PLW'(1);
              issuing       <= 1'b1;
              rd_live       <= 1'b0;
            end
          end
          default: begin
            issuing <= 1'b0;
          end
        endcase
      end else if (state == SEQ_SCAN) begin
        if (scan_hit || scan_end) begin
          issuing <= 1'b0;
          rd_live <= 1'b0;
        end else begin
          rd_live <= issuing;
          if (issuing && (scan_addr == LAST_IDX)) begin
            issuing <= 1'b0;
          end
        end
        if (scan_hit || (scan_end && prefix_full)) begin
          prefix_bits <= '0;
          prefix_len  <= '0;
        end
      end
    end
  end

  // scan address and result registers carry payload only
  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_addr <= '0;
    end else if (state == SEQ_SCAN) begin
      rd_idx <= scan_addr;
      if (issuing && (scan_addr != LAST_IDX)) begin
        scan_addr <= scan_addr + IW'(1);
      end
    end

    if (accept) begin
      res_symbol_valid <= 1'b0;
      res_symbol       <= '0;
      res_status       <= (req_type == REQ_BIT && limited) ? STAT_LIMIT : STAT_OK;
    end else if (state == SEQ_SCAN) begin
      if (scan_hit) begin
        res_symbol_valid <= 1'b1;
        res_symbol       <= SYM_W'(rd_idx);
      end else if (scan_end && prefix_full) begin
        res_status <= STAT_OVF;
      end
    end
  end

endmodule

>>> design/huffman_table_decoder_core.sv
// top level of the huffman table decoder: config register, output register, sequencer, table
//
// Every request gives exactly one result beat. Load, clear, unused and out-of-limit bit
// requests go from accept straight to the result hold state. A decode bit walks the code
// table from entry 0 upward through the single registered read port of the table memory,
// one entry per cycle, and stops at the first match or, on a miss, after the last entry.
// s_tready is low while an item is at work; a finished result sits in the output register,
// so the next item is taken while the previous result waits for m_tready. The table is
// empty right after reset.
module huffman_table_decoder_core
  import htd_pkg::*;
#(
  parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // entry_symbol[7:0], entry_length[13:8], entry_code[45:14], coded_bit[46], zero[47]
  input  logic [47:0]      s_tdata,
  // req_type[1:0]
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // decoded_symbol[7:0]
  output logic [7:0]       m_tdata,
  // symbol_valid[0], status[2:1]
  output logic [2:0]       m_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_SIZE);

  logic [CNT_W-1:0]  stream_bit_limit;
  logic              out_free;
  logic              res_valid, res_symbol_valid;
  logic [SYM_W-1:0]  res_symbol;
  logic [STAT_W-1:0] res_status;
  tbl_ctl_t          tbl_ctl;
  logic [IW-1:0]     tbl_wr_idx, tbl_rd_idx;
  logic [LEN_W-1:0]  tbl_wr_len, tbl_rd_len;
  logic [CODE_W-1:0] tbl_wr_code, tbl_rd_code;
  logic              tbl_rd_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_bit_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      stream_bit_limit <= cfg_data;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_tdata <= res_symbol;
      m_tuser <= {res_status, res_symbol_valid};
    end
  end

  htd_seq #(
    .TABLE_SIZE   (TABLE_SIZE),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .req_type         (s_tuser),
    .entry_symbol     (s_tdata[7:0]),
    .entry_length     (s_tdata[13:8]),
    .entry_code       (s_tdata[45:14]),
    .coded_bit        (s_tdata[46]),
    .limit            (stream_bit_limit),
    .out_free         (out_free),
    .res_valid        (res_valid),
    .res_symbol_valid (res_symbol_valid),
    .res_symbol       (res_symbol),
    .res_status       (res_status),
    .tbl_ctl          (tbl_ctl),
    .tbl_wr_idx       (tbl_wr_idx),
    .tbl_wr_len       (tbl_wr_len),
    .tbl_wr_code      (tbl_wr_code),
    .tbl_rd_idx       (tbl_rd_idx),
    .tbl_rd_len       (tbl_rd_len),
    .tbl_rd_code      (tbl_rd_code),
    .tbl_rd_ok        (tbl_rd_ok)
  );

  htd_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl_ctl),
    .wr_idx  (tbl_wr_idx),
    .wr_len  (tbl_wr_len),
    .wr_code (tbl_wr_code),
    .rd_idx  (tbl_rd_idx),
    .rd_len  (tbl_rd_len),
    .rd_code (tbl_rd_code),
    .rd_ok   (tbl_rd_ok)
  );

endmodule

>>> design/htd_checker.sv
// port-level checker for the huffman table decoder, bound to the top level
`include "assert_macros.svh"

module htd_checker
  import htd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [7:0]       m_tdata,
  input logic [2:0]       m_tuser
);

  // a stalled result beat holds
  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // one item at a time: no accept right after an accept
  `CHK_ASSERT(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "input taken while an item is at work")

  // a decoded symbol always comes with ok status
  `CHK_ASSERT(a_sym_ok, clk, rst, m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STAT_OK, "decoded symbol with error status")

  // no symbol means a zero symbol field
  `CHK_ASSERT(a_nosym_zero, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0, "symbol field set without a decoded symbol")

endmodule

bind huffman_table_decoder_core htd_checker u_htd_checker (.*);

>>> tb/htd_checker.sv
// scoreboard for the huffman table decoder core: predicts every result beat and compares it
`timescale 1ns / 100ps
module htd_scoreboard
  import htd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  // entry_symbol[7:0], entry_length[13:8], entry_code[45:14], coded_bit[46], zero[47]
  input  logic [47:0]      s_tdata,
  // req_type[1:0]
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  // decoded_symbol[7:0]
  input  logic [7:0]       m_tdata,
  // symbol_valid[0], status[2:1]
  input  logic [2:0]       m_tuser,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic              sym_valid;
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] status;
  } decode_result_t;

  logic [LEN_W-1:0]  len_tbl  [TABLE_SIZE_DEF];
  logic [CODE_W-1:0] code_tbl [TABLE_SIZE_DEF];
  logic [CODE_W-1:0] prefix;
  logic [LEN_W-1:0]  prefix_len;
  logic [CNT_W-1:0]  consumed;
  logic [CNT_W-1:0]  bit_limit;
  decode_result_t    expected_results [$];
  int                beat_no;

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      len_tbl[i]  = '0;
      code_tbl[i] = '0;
    end
    prefix     = '0;
    prefix_len = '0;
  endfunction

  function automatic decode_result_t next_decode_result(input logic [REQ_W-1:0]  req,
                                                        input logic [SYM_W-1:0]  sym,
                                                        input logic [LEN_W-1:0]  len,
                                                        input logic [CODE_W-1:0] code,
                                                        input logic              cbit);
    decode_result_t r;
    logic hit;
    r   = '0;
    hit = 1'b0;
    case (req)
      REQ_LOAD: begin
        len_tbl[sym]  = len;
        // bits above the code length are dropped, lengths of 32 and up keep all
        code_tbl[sym] = code & ~({CODE_W{1'b1}} << len);
      end
      REQ_CLEAR: wipe_table();
      REQ_BIT: begin
        if (consumed >= bit_limit) begin
          r.status = STAT_LIMIT;
        end else begin
          consumed   = consumed + 1'b1;
          prefix     = {prefix[CODE_W-2:0], cbit};
          prefix_len = prefix_len + 1'b1;
          // lowest matching symbol wins
          for (int i = 0; i < TABLE_SIZE_DEF && !hit; i++) begin
            if (len_tbl[i] != '0 && len_tbl[i] == prefix_len && code_tbl[i] == prefix) begin
              hit   = 1'b1;
              r.sym = SYM_W'(i);
            end
          end
          if (hit) begin
            r.sym_valid = 1'b1;
            prefix      = '0;
            prefix_len  = '0;
          end else if (prefix_len >= LEN_W'(MAX_CODE_LEN_DEF)) begin
            r.status   = STAT_OVF;
            prefix     = '0;
            prefix_len = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what);
    if (fail_count < 40) $display("[%0t] mismatch on result beat %0d: %s", $time, beat_no, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    decode_result_t pred;
    if (rst) begin
      wipe_table();
      consumed   = '0;
      bit_limit  = '1;
      beat_no    = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // results first: a beat leaving now never belongs to an item taken at this edge
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata, m_tuser[2:1]};
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected beat valid=%0b sym=%0d status=%0d",
                           got.sym_valid, got.sym, got.status));
        end else begin
          want = expected_results.pop_front();
          if (got.sym_valid !== want.sym_valid)
            report($sformatf("symbol_valid %0b, expected %0b", got.sym_valid, want.sym_valid));
          if (got.sym !== want.sym)
            report($sformatf("decoded_symbol %0d, expected %0d", got.sym, want.sym));
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        end
        beat_no++;
      end
      if (cfg_valid && cfg_ready) bit_limit = cfg_data;
      if (s_tvalid && s_tready) begin
        pred = next_decode_result(s_tuser, s_tdata[7:0], s_tdata[13:8],
                                  s_tdata[45:14], s_tdata[46]);
        expected_results.insert(expected_results.size(), pred);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb_top.sv
// top of the huffman table decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import htd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED      = 2'd3;
  localparam logic [CNT_W-1:0] LIMIT_MAX       = '1;
  localparam int               TARGET_ITEMS    = 1400;
  localparam int               CALM_ITEMS      = 250;
  localparam int               WATCHDOG_CYCLES = 4000;
  localparam int               DRAIN_CYCLES    = 300;

  logic             clk;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [47:0]      s_tdata   = '0;
  logic [1:0]       s_tuser   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [7:0]       m_tdata;
  logic [2:0]       m_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;
  int               fail_count;
  int               pending;

  bit               idle_on = 1'b1;
  int               hold_left;
  int               quiet_cycles;
  int               n_items;
  logic [CNT_W-1:0] stream_pos;
  logic [CNT_W-1:0] limit_now;
  // code book currently loaded into the block
  logic [7:0]       cb_sym  [$];
  logic [5:0]       cb_len  [$];
  logic [31:0]      cb_code [$];

  huffman_table_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  htd_scoreboard result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready  <= 1'b0;
      hold_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high into the next beat; other tasks drop it first
  task automatic send_item(input logic [1:0] req, input logic [7:0] sym, input logic [5:0] len,
                           input logic [31:0] code, input logic cbit);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {1'b0, cbit, code, len, sym};
    do @(posedge clk); while (!s_tready);
    n_items++;
    if (req == REQ_BIT && stream_pos < limit_now) begin
      stream_pos++;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  task automatic send_noise();
    int pick;
    logic [1:0] req;
    pick = $urandom_range(0, 19);
    if (pick < 6) req = REQ_LOAD;
    else if (pick < 17) req = REQ_BIT;
    else if (pick < 18) req = REQ_CLEAR;
    else req = REQ_UNUSED;
    send_item(req, 8'($urandom), 6'($urandom_range(0, 63)), $urandom, 1'($urandom));
  endtask

  // first nbits of code book entry k, msb first
  task automatic send_code(input int k, input int nbits);
    for (int b = 0; b < nbits; b++) begin
      send_item(REQ_BIT, 8'($urandom), 6'($urandom), $urandom, cb_code[k][cb_len[k] - 1 - b]);
    end
  endtask

  // clear the block and load a fresh code book: canonical prefix code or random codes
  task automatic build_table(input int n, input int min_len, input int max_len,
                             input bit canonical);
    int lens [$];
    int start;
    int stride;
    int off;
    int j;
    longint code;
    logic [31:0] junk;
    cb_sym.delete();
    cb_len.delete();
    cb_code.delete();
    for (int i = 0; i < n; i++) lens.insert(lens.size(), $urandom_range(min_len, max_len));
    lens.sort();
    start  = $urandom_range(0, 255);
    stride = 2 * $urandom_range(0, 127) + 1;
    code   = 0;
    for (int i = 0; i < n; i++) begin
      if (!canonical) code = $urandom & ((longint'(1) << lens[i]) - 1);
      else if (i > 0) code = (code + 1) << (lens[i] - lens[i-1]);
      if (code >= (longint'(1) << lens[i])) break;
      cb_sym.insert(cb_sym.size(), 8'(start + i * stride));
      cb_len.insert(cb_len.size(), 6'(lens[i]));
      cb_code.insert(cb_code.size(), 32'(code));
    end
    send_item(REQ_CLEAR, 8'($urandom), 6'($urandom), $urandom, 1'($urandom));
    off = $urandom_range(0, cb_sym.size() - 1);
    for (int i = 0; i < cb_sym.size(); i++) begin
      j    = (off + i) % cb_sym.size();
      junk = $urandom;
      // junk above the code length must be masked by the block
      send_item(REQ_LOAD, cb_sym[j], cb_len[j], cb_code[j] | (junk << cb_len[j]), 1'($urandom));
    end
  endtask

  initial begin
    int pick;
    int k;
    stream_pos = '0;
    limit_now  = LIMIT_MAX;
    n_items    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_limit(LIMIT_MAX);
    send_item(REQ_LOAD, 8'd0,   6'd1,  32'hFFFF_FFFE, 1'b0);
    send_item(REQ_LOAD, 8'd1,   6'd1,  32'h0000_0000, 1'b1);  // same code as symbol 0
    send_item(REQ_LOAD, 8'd255, 6'd2,  32'hFFFF_FFFF, 1'b0);
    send_item(REQ_LOAD, 8'd7,   6'd63, 32'hAAAA_AAAA, 1'b1);  // can never match
    send_item(REQ_LOAD, 8'd9,   6'd0,  32'h0000_0001, 1'b0);  // absent symbol
    send_item(REQ_LOAD, 8'd128, 6'd32, 32'hFFFF_FFFF, 1'b0);
    send_item(REQ_BIT,  8'hFF,  6'h3F, 32'hFFFF_FFFF, 1'b0);
    send_item(REQ_BIT,  8'h00,  6'h00, 32'h0000_0000, 1'b1);
    send_item(REQ_BIT,  8'h55,  6'h2A, 32'h5555_5555, 1'b1);
    send_item(REQ_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_BIT,  8'h00,  6'h00, 32'h0000_0000, 1'b1);  // partial prefix, then clear
    send_item(REQ_CLEAR, 8'hAA, 6'h15, 32'hAAAA_AAAA, 1'b0);
    // empty table: the 32nd bit drops the prefix
    repeat (32) send_item(REQ_BIT, 8'h00, 6'h00, 32'h0000_0000, 1'b0);
    write_limit(stream_pos);
    send_item(REQ_BIT, 8'h00, 6'h00, 32'h0000_0000, 1'b1);
    write_limit('0);
    send_item(REQ_BIT, 8'h00, 6'h00, 32'h0000_0000, 1'b0);
    write_limit(LIMIT_MAX);

    while (n_items < TARGET_ITEMS) begin
      idle_on = (n_items < TARGET_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) write_limit(LIMIT_MAX);
      else if (pick < 8) write_limit(stream_pos + CNT_W'($urandom_range(0, 80)));
      else if (pick == 8) write_limit(stream_pos >> 1);
      else write_limit(CNT_W'({$urandom, $urandom} >> 16));

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        build_table($urandom_range(2, 40), 1, $urandom_range(3, 12), 1'b1);
        repeat ($urandom_range(20, 60)) begin
          k    = $urandom_range(0, cb_sym.size() - 1);
          pick = $urandom_range(0, 9);
          if (pick == 0) send_noise();
          else if (pick == 1) send_code(k, $urandom_range(0, cb_len[k] - 1));
          else send_code(k, cb_len[k]);
        end
      end else if (pick < 8) begin
        // long codes: full-length hits and prefixes that run out
        build_table($urandom_range(1, 4), 24, 32, 1'b0);
        repeat (2) begin
          send_code($urandom_range(0, cb_sym.size() - 1),
                    cb_len[$urandom_range(0, cb_sym.size() - 1)] > 0 ? 0 : 0);
          k = $urandom_range(0, cb_sym.size() - 1);
          send_code(k, cb_len[k]);
          repeat (32) send_item(REQ_BIT, 8'($urandom), 6'($urandom), $urandom, 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(30, 80)) send_noise();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/htd_pkg.sv
design/htd_table.sv
design/htd_seq.sv
design/huffman_table_decoder_core.sv
design/htd_checker.sv
tb/htd_checker.sv
tb/tb_top.sv
